>>> rtl/core/target_bearing_and_distance_defines.svh
// ----------------------------------------------------------------------------
// Target bearing and distance: assertion macros
// Shared concurrent assertion forms, clocked on clk, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef TARGET_BEARING_AND_DISTANCE_DEFINES_SVH
`define TARGET_BEARING_AND_DISTANCE_DEFINES_SVH

// same-cycle implication
`define TBD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define TBD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/core/tbd_pkg.sv
// ----------------------------------------------------------------------------
// tbd_pkg
// Types, constants and the arctangent table of the bearing/distance pipeline.
// ----------------------------------------------------------------------------
package tbd_pkg;

  localparam int CORDIC_STAGES_DEF = 16;
  localparam int POS_W = 32;
  localparam int ANG_W = 16;
  localparam int DIST_W = 33;
  localparam int Z_W = 32;
  localparam int GUARD_W = 16;
  localparam int CW = 52;

  localparam int IN_W = 80;
  localparam int OUT_W = 72;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] CFG_CAMERA_X = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CAMERA_Y = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CAMERA_HEADING = 2'd2;

  localparam logic [31:0] INV_GAIN = 32'h9B74_EDA8;
  localparam logic [Z_W-1:0] Z_HALF_TURN = 32'h8000_0000;

  typedef struct packed {
    logic vld;
    logic zero;
    logic [CW-1:0] x;
    logic [CW-1:0] y;
    logic [Z_W-1:0] z;
    logic [ANG_W-1:0] hdg;
  } cordic_vec_t;

  typedef struct packed {
    logic vld;
    logic [DIST_W-1:0] mag;
    logic [ANG_W-1:0] dir;
    logic [ANG_W-1:0] hdg;
  } polar_res_t;

  function automatic logic [Z_W-1:0] atan_bam(input logic [4:0] idx);
    logic [Z_W-1:0] a;
    case (idx)
      5'd0: a = 32'd536870912;
      5'd1: a = 32'd316933406;
      5'd2: a = 32'd167458907;
      5'd3: a = 32'd85004756;
      5'd4: a = 32'd42667331;
      5'd5: a = 32'd21354465;
      5'd6: a = 32'd10679838;
      5'd7: a = 32'd5340245;
      5'd8: a = 32'd2670163;
      5'd9: a = 32'd1335087;
      5'd10: a = 32'd667544;
      5'd11: a = 32'd333772;
      5'd12: a = 32'd166886;
      5'd13: a = 32'd83443;
      5'd14: a = 32'd41722;
      5'd15: a = 32'd20861;
      5'd16: a = 32'd10430;
      5'd17: a = 32'd5215;
      5'd18: a = 32'd2608;
      5'd19: a = 32'd1304;
      5'd20: a = 32'd652;
      5'd21: a = 32'd326;
      5'd22: a = 32'd163;
      5'd23: a = 32'd81;
      5'd24: a = 32'd41;
      5'd25: a = 32'd20;
      5'd26: a = 32'd10;
      5'd27: a = 32'd5;
      5'd28: a = 32'd3;
      5'd29: a = 32'd1;
      5'd30: a = 32'd1;
      default: a = 32'd0;
    endcase
    return a;
  endfunction

endpackage

>>> rtl/core/target_bearing_and_distance.sv
// ----------------------------------------------------------------------------
// target_bearing_and_distance
// Direction and range from each target to the camera by a CORDIC vectoring
// chain, with the target and camera headings applied to the direction.
//
//   channel  | direction | payload
//   ---------+-----------+---------------------------------------------------
//   in_      | request   | target_x, target_y, target_heading
//   out_     | result    | visible_angle, bearing_angle, distance
//   cfg_     | write     | camera_x (0), camera_y (1), camera_heading (2)
//
// One request per cycle while the chain is not held. The pipeline has one
// front stage, one cell per micro-rotation, three gain stages and one output
// register. The whole chain holds while the output register is full and not
// taken. Reset clears the valid bits and the camera registers; cfg_ready is
// always high.
// ----------------------------------------------------------------------------
`include "target_bearing_and_distance_defines.svh"

module target_bearing_and_distance #(
  parameter int CORDIC_STAGES = tbd_pkg::CORDIC_STAGES_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  // [31:0] target_x, [63:32] target_y, [79:64] target_heading
  input  logic [tbd_pkg::IN_W-1:0]       in_tdata,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  // [15:0] visible_angle, [31:16] bearing_angle, [64:32] distance, rest zero
  output logic [tbd_pkg::OUT_W-1:0]      out_tdata,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [tbd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [tbd_pkg::CFG_DATA_W-1:0] cfg_data
);
  import tbd_pkg::*;

  logic [POS_W-1:0] cam_x_r;
  logic [POS_W-1:0] cam_y_r;
  logic [ANG_W-1:0] cam_hdg_r;

  logic             adv;
  cordic_vec_t      stg [0:CORDIC_STAGES];
  polar_res_t       res;

  logic             out_vld_r;
  logic [OUT_W-1:0] out_data_r;
  logic [OUT_W-1:0] out_data_nxt;
  logic [ANG_W-1:0] vis_ang;
  logic [ANG_W-1:0] brg_ang;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cam_x_r   <= '0;
      cam_y_r   <= '0;
      cam_hdg_r <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_CAMERA_X:       cam_x_r   <= cfg_data;
        CFG_CAMERA_Y:       cam_y_r   <= cfg_data;
        CFG_CAMERA_HEADING: cam_hdg_r <= cfg_data[ANG_W-1:0];
        default: ;
      endcase
    end
  end

  assign adv       = !out_vld_r || out_tready;
  assign in_tready = adv;

  tbd_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (adv),
    .in_vld  (in_tvalid),
    .cam_x   (cam_x_r),
    .cam_y   (cam_y_r),
    .tgt_x   (in_tdata[31:0]),
    .tgt_y   (in_tdata[63:32]),
    .tgt_hdg (in_tdata[79:64]),
    .vec_o   (stg[0])
  );

  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cell
    tbd_cell #(
      .SHIFT (i)
    ) u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .en    (adv),
      .vec_i (stg[i]),
      .vec_o (stg[i+1])
    );
  end

  tbd_gain u_gain (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (adv),
    .vec_i (stg[CORDIC_STAGES]),
    .res_o (res)
  );

  always_comb begin
    vis_ang      = res.dir + res.hdg;
    brg_ang      = res.dir - cam_hdg_r;
    out_data_nxt = {{(OUT_W-2*ANG_W-DIST_W){1'b0}}, res.mag, brg_ang, vis_ang};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (adv) begin
      out_vld_r <= res.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_data_r;

  `TBD_ASSERT_NOW(a_hold_on_stall, out_tvalid && !out_tready, !in_tready, "input open in stall")
  `TBD_ASSERT_NOW(a_x_nonneg, stg[CORDIC_STAGES].vld, !stg[CORDIC_STAGES].x[CW-1], "x negative")
  `TBD_ASSERT_NEXT(a_res_to_out, res.vld && adv, out_tvalid, "result lost")

endmodule

>>> rtl/core/tbd_front.sv
// ----------------------------------------------------------------------------
// tbd_front
// Offset from target to camera, guard scaling and half-turn pre-rotation.
// ----------------------------------------------------------------------------
module tbd_front (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        en,
  input  logic                        in_vld,
  input  logic [tbd_pkg::POS_W-1:0]   cam_x,
  input  logic [tbd_pkg::POS_W-1:0]   cam_y,
  input  logic [tbd_pkg::POS_W-1:0]   tgt_x,
  input  logic [tbd_pkg::POS_W-1:0]   tgt_y,
  input  logic [tbd_pkg::ANG_W-1:0]   tgt_hdg,
  output tbd_pkg::cordic_vec_t        vec_o
);
  import tbd_pkg::*;

  logic signed [POS_W:0] dx;
  logic signed [POS_W:0] dy;
  logic signed [CW-1:0]  xg;
  logic signed [CW-1:0]  yg;
  cordic_vec_t           vec_nxt;
  cordic_vec_t           vec_r;

  always_comb begin
    dx = $signed({cam_x[POS_W-1], cam_x}) - $signed({tgt_x[POS_W-1], tgt_x});
    dy = $signed({cam_y[POS_W-1], cam_y}) - $signed({tgt_y[POS_W-1], tgt_y});
    xg = {{(CW-POS_W-1-GUARD_W){dx[POS_W]}}, dx, {GUARD_W{1'b0}}};
    yg = {{(CW-POS_W-1-GUARD_W){dy[POS_W]}}, dy, {GUARD_W{1'b0}}};
    vec_nxt.vld  = in_vld;
    vec_nxt.zero = (dx == '0) && (dy == '0);
    vec_nxt.hdg  = tgt_hdg;
    if (dx[POS_W]) begin
      vec_nxt.x = -xg;
      vec_nxt.y = -yg;
      vec_nxt.z = Z_HALF_TURN;
    end else begin
      vec_nxt.x = xg;
      vec_nxt.y = yg;
      vec_nxt.z = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vec_r.vld <= 1'b0;
    end else if (en) begin
      vec_r.vld <= vec_nxt.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      vec_r.zero <= vec_nxt.zero;
      vec_r.x    <= vec_nxt.x;
      vec_r.y    <= vec_nxt.y;
      vec_r.z    <= vec_nxt.z;
      vec_r.hdg  <= vec_nxt.hdg;
    end
  end

  assign vec_o = vec_r;

endmodule

>>> rtl/core/tbd_cell.sv
// ----------------------------------------------------------------------------
// tbd_cell
// One vectoring micro-rotation: drive y towards zero, accumulate the angle.
// ----------------------------------------------------------------------------
module tbd_cell #(
  parameter int SHIFT = 0
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 en,
  input  tbd_pkg::cordic_vec_t vec_i,
  output tbd_pkg::cordic_vec_t vec_o
);
  import tbd_pkg::*;

  localparam logic [Z_W-1:0] ATAN_STEP = atan_bam(5'(SHIFT));

  logic signed [CW-1:0] xs;
  logic signed [CW-1:0] ys;
  cordic_vec_t          vec_nxt;
  cordic_vec_t          vec_r;

  always_comb begin
    xs = $signed(vec_i.x) >>> SHIFT;
    ys = $signed(vec_i.y) >>> SHIFT;
    vec_nxt = vec_i;
    if (!vec_i.y[CW-1]) begin
      vec_nxt.x = vec_i.x + ys;
      vec_nxt.y = vec_i.y - xs;
      vec_nxt.z = vec_i.z + ATAN_STEP;
    end else begin
      vec_nxt.x = vec_i.x - ys;
      vec_nxt.y = vec_i.y + xs;
      vec_nxt.z = vec_i.z - ATAN_STEP;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vec_r.vld <= 1'b0;
    end else if (en) begin
      vec_r.vld <= vec_nxt.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      vec_r.zero <= vec_nxt.zero;
      vec_r.x    <= vec_nxt.x;
      vec_r.y    <= vec_nxt.y;
      vec_r.z    <= vec_nxt.z;
      vec_r.hdg  <= vec_nxt.hdg;
    end
  end

  assign vec_o = vec_r;

endmodule

>>> rtl/core/tbd_gain.sv
// ----------------------------------------------------------------------------
// tbd_gain
// Gain correction of the vector length, guard removal, saturation and
// rounding of the direction to a 16-bit binary angle.
// ----------------------------------------------------------------------------
module tbd_gain (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 en,
  input  tbd_pkg::cordic_vec_t vec_i,
  output tbd_pkg::polar_res_t  res_o
);
  import tbd_pkg::*;

  localparam int XH_W = CW - 32;
  localparam int PH_W = XH_W + 32;
  localparam int SC_W = PH_W + 1;
  localparam int RN_W = SC_W + 1;

  // multiply stage
  logic            a_vld_r;
  logic            a_zero_r;
  logic [63:0]     a_plo_r;
  logic [PH_W-1:0] a_phi_r;
  logic [Z_W-1:0]  a_z_r;
  logic [ANG_W-1:0] a_hdg_r;

  // sum stage
  logic            b_vld_r;
  logic            b_zero_r;
  logic [SC_W-1:0] b_sc_r;
  logic [SC_W-1:0] b_sc_nxt;
  logic [64:0]     lo_rnd;
  logic [Z_W-1:0]  b_z_r;
  logic [ANG_W-1:0] b_hdg_r;

  // round stage
  logic [RN_W-1:0] rnd;
  logic [RN_W-GUARD_W-1:0] dist_full;
  polar_res_t      res_nxt;
  polar_res_t      res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
      b_vld_r <= 1'b0;
      res_r.vld <= 1'b0;
    end else if (en) begin
      a_vld_r <= vec_i.vld;
      b_vld_r <= a_vld_r;
      res_r.vld <= res_nxt.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_zero_r <= vec_i.zero;
      a_plo_r  <= 64'(vec_i.x[31:0]) * 64'(INV_GAIN);
      a_phi_r  <= PH_W'(vec_i.x[CW-1:32]) * PH_W'(INV_GAIN);
      a_z_r    <= vec_i.z;
      a_hdg_r  <= vec_i.hdg;
    end
  end

  always_comb begin
    lo_rnd   = {1'b0, a_plo_r} + 65'h0_8000_0000;
    b_sc_nxt = {1'b0, a_phi_r} + SC_W'(lo_rnd[64:32]);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b_zero_r <= a_zero_r;
      b_sc_r   <= b_sc_nxt;
      b_z_r    <= a_z_r;
      b_hdg_r  <= a_hdg_r;
    end
  end

  always_comb begin
    rnd       = {1'b0, b_sc_r} + RN_W'(1 << (GUARD_W - 1));
    dist_full = rnd[RN_W-1:GUARD_W];
    res_nxt.vld = b_vld_r;
    res_nxt.hdg = b_hdg_r;
    if (b_zero_r) begin
      res_nxt.mag = '0;
      res_nxt.dir = '0;
    end else begin
      res_nxt.mag = (|dist_full[RN_W-GUARD_W-1:DIST_W]) ? {DIST_W{1'b1}}
                                                       : dist_full[DIST_W-1:0];
      res_nxt.dir = b_z_r[Z_W-1:Z_W-ANG_W] + ANG_W'(b_z_r[Z_W-ANG_W-1]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res_r.mag <= res_nxt.mag;
      res_r.dir <= res_nxt.dir;
      res_r.hdg <= res_nxt.hdg;
    end
  end

  assign res_o = res_r;

endmodule

>>> test/target_bearing_and_distance_tb.sv
// ----------------------------------------------------------------------------
// Target bearing and distance testbench
// Streams target positions and headings through the polar pipeline and
// compares every result with a bit-exact CORDIC vectoring predictor or a typed
// value, across several camera settings including the position and heading
// extremes. A directed table covers zero vectors, axis-aligned and extreme
// offsets. Random targets follow, with bursty idling on both channels, one
// long receiver hold-off and a final stretch at full rate.
// ----------------------------------------------------------------------------
module target_bearing_and_distance_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STAGES = 16;
  localparam int LATENCY = STAGES + 5;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int LONG_HOLD = 400;
  localparam int RANDOM_PHASES = 10;
  localparam int PHASE_ITEMS = 170;
  localparam logic [63:0] GAIN_INV_Q32 = 64'h9B74_EDA8;
  localparam logic [32:0] DIST_MAX = 33'h1_FFFF_FFFF;

  typedef struct packed {
    logic [15:0] heading;
    logic [31:0] y;
    logic [31:0] x;
  } target_t;

  typedef struct packed {
    logic [32:0] distance;
    logic [15:0] bearing;
    logic [15:0] visible;
  } polar_t;

  typedef enum bit {ROW_TARGET, ROW_CAMERA} row_kind_t;

  typedef struct packed {
    row_kind_t kind;
    target_t item;
    logic typed;
    polar_t res;
  } row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [tbd_pkg::IN_W-1:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [tbd_pkg::OUT_W-1:0] out_tdata;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [tbd_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [tbd_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  logic [31:0] cam_x_q = '0;
  logic [31:0] cam_y_q = '0;
  logic [15:0] cam_hdg_q = '0;
  polar_t polar_q [$];
  int unsigned mismatches = 0;
  int stall_cycles = 0;
  bit quiet = 1'b0;
  bit long_hold_due = 1'b0;
  int unsigned atan_bam [STAGES] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
    10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886,
    83443, 41722, 20861
  };

  target_bearing_and_distance dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic polar_t predict_polar(input target_t t);
    longint dx, dy, x, y, xs, ys;
    logic [31:0] z;
    logic [32:0] zr;
    logic [63:0] ux, scaled, dist64;
    logic [15:0] dir;
    logic [32:0] dist_sat;
    polar_t r;
    int i;
    dx = longint'($signed(cam_x_q)) - longint'($signed(t.x));
    dy = longint'($signed(cam_y_q)) - longint'($signed(t.y));
    dir = '0;
    dist_sat = '0;
    if (dx != 0 || dy != 0) begin
      x = dx <<< 16;
      y = dy <<< 16;
      z = '0;
      if (x < 0) begin
        x = -x;
        y = -y;
        z = 32'h8000_0000;
      end
      for (i = 0; i < STAGES; i++) begin
        xs = x >>> i;
        ys = y >>> i;
        if (y >= 0) begin
          x = x + ys;
          y = y - xs;
          z = z + atan_bam[i];
        end else begin
          x = x - ys;
          y = y + xs;
          z = z - atan_bam[i];
        end
      end
      zr = {1'b0, z} + 33'h8000;
      dir = zr[31:16];
      ux = x;
      scaled = (ux >> 32) * GAIN_INV_Q32
             + ((((ux & 64'hFFFF_FFFF) * GAIN_INV_Q32) + 64'h8000_0000) >> 32);
      dist64 = (scaled + 64'h8000) >> 16;
      dist_sat = (dist64 > 64'(DIST_MAX)) ? DIST_MAX : dist64[32:0];
    end
    r.visible = dir + t.heading;
    r.bearing = dir - cam_hdg_q;
    r.distance = dist_sat;
    return r;
  endfunction

  task automatic write_reg(input logic [tbd_pkg::CFG_IDX_W-1:0] idx, input logic [31:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic set_camera(input logic [31:0] cx, input logic [31:0] cy,
                            input logic [15:0] ch);
    write_reg(tbd_pkg::CFG_CAMERA_X, cx);
    write_reg(tbd_pkg::CFG_CAMERA_Y, cy);
    write_reg(tbd_pkg::CFG_CAMERA_HEADING, {16'h0000, ch});
    cfg_valid <= 1'b0;
    cam_x_q = cx;
    cam_y_q = cy;
    cam_hdg_q = ch;
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (polar_q.size() != 0) @(posedge clk);
  endtask

  task automatic push_target(input target_t t, input logic typed, input polar_t typed_res);
    if (!quiet && $urandom_range(5) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= t;
    do @(posedge clk); while (!in_tready);
    polar_q.push_back(typed ? typed_res : predict_polar(t));
  endtask

  initial begin : receiver
    do @(posedge clk); while (!rst_n);
    forever begin
      if (long_hold_due) begin
        long_hold_due = 1'b0;
        out_tready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end else if (!quiet && $urandom_range(3) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 10)) @(posedge clk);
      end else begin
        out_tready <= 1'b1;
        repeat ($urandom_range(1, 20)) @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    polar_t got, want;
    if (rst_n && out_tvalid && out_tready) begin
      got = out_tdata[64:0];
      if (polar_q.size() == 0) begin
        $error("result with no request outstanding: %h", out_tdata);
        mismatches++;
      end else begin
        want = polar_q.pop_front();
        if (got.visible !== want.visible) begin
          $error("visible_angle: expected %h, got %h", want.visible, got.visible);
          mismatches++;
        end
        if (got.bearing !== want.bearing) begin
          $error("bearing_angle: expected %h, got %h", want.bearing, got.bearing);
          mismatches++;
        end
        if (got.distance !== want.distance) begin
          $error("distance: expected %h, got %h", want.distance, got.distance);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)
        || (cfg_valid && cfg_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin : stimulus
    row_t plan [$];
    target_t t;
    logic [31:0] cx, cy;
    int p, j, kind;
    plan.push_back('{ROW_TARGET, '{16'h0000, 32'h0, 32'h0}, 1'b1, '{33'd0, 16'h0000, 16'h0000}});
    plan.push_back('{ROW_TARGET, '{16'h7FFF, 32'h0, 32'h0}, 1'b1, '{33'd0, 16'h0000, 16'h7FFF}});
    plan.push_back('{ROW_TARGET, '{16'h8000, 32'h0, 32'h0}, 1'b1, '{33'd0, 16'h0000, 16'h8000}});
    plan.push_back('{ROW_TARGET, '{16'h0000, 32'h0, 32'h0001_0000}, 1'b0, '0});
    plan.push_back('{ROW_TARGET, '{16'h0000, 32'h0, 32'hFFFF_0000}, 1'b0, '0});
    plan.push_back('{ROW_TARGET, '{16'h0000, 32'h0001_0000, 32'h0}, 1'b0, '0});
    plan.push_back('{ROW_TARGET, '{16'h0000, 32'hFFFF_0000, 32'h0}, 1'b0, '0});
    plan.push_back('{ROW_TARGET, '{16'h1234, 32'h1, 32'h1}, 1'b0, '0});
    plan.push_back('{ROW_TARGET, '{16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF}, 1'b0, '0});
    plan.push_back('{ROW_TARGET, '{16'h7FFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF}, 1'b0, '0});
    plan.push_back('{ROW_TARGET, '{16'h8000, 32'h8000_0000, 32'h8000_0000}, 1'b0, '0});
    plan.push_back('{ROW_TARGET, '{16'h4000, 32'h8000_0000, 32'h7FFF_FFFF}, 1'b0, '0});
    plan.push_back('{ROW_TARGET, '{16'hC000, 32'h7FFF_FFFF, 32'h8000_0000}, 1'b0, '0});
    plan.push_back('{ROW_CAMERA, '{16'h7FFF, 32'h8000_0000, 32'h7FFF_FFFF}, 1'b0, '0});
    plan.push_back('{ROW_TARGET, '{16'h1111, 32'h8000_0000, 32'h7FFF_FFFF}, 1'b1,
                     '{33'd0, 16'h8001, 16'h1111}});
    plan.push_back('{ROW_TARGET, '{16'h0000, 32'h7FFF_FFFF, 32'h8000_0000}, 1'b0, '0});
    plan.push_back('{ROW_TARGET, '{16'h7FFF, 32'h8000_0000, 32'h8000_0000}, 1'b0, '0});
    plan.push_back('{ROW_TARGET, '{16'h2468, 32'h0, 32'h0}, 1'b0, '0});
    plan.push_back('{ROW_CAMERA, '{16'h8000, 32'h7FFF_FFFF, 32'h8000_0000}, 1'b0, '0});
    plan.push_back('{ROW_TARGET, '{16'h7FFF, 32'h7FFF_FFFF, 32'h8000_0000}, 1'b1,
                     '{33'd0, 16'h8000, 16'h7FFF}});
    plan.push_back('{ROW_TARGET, '{16'h0000, 32'h8000_0000, 32'h7FFF_FFFF}, 1'b0, '0});
    plan.push_back('{ROW_TARGET, '{16'h5555, 32'h0, 32'h0}, 1'b0, '0});
    plan.push_back('{ROW_CAMERA, '{16'h0000, 32'h0, 32'h0}, 1'b0, '0});

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (plan[i]) begin
      if (plan[i].kind == ROW_CAMERA) begin
        drain();
        set_camera(plan[i].item.x, plan[i].item.y, plan[i].item.heading);
      end else begin
        push_target(plan[i].item, plan[i].typed, plan[i].res);
      end
    end

    for (p = 0; p < RANDOM_PHASES; p++) begin
      drain();
      case (p)
        0: set_camera(32'h7FFF_FFFF, 32'h7FFF_FFFF, 16'h7FFF);
        1: set_camera(32'h8000_0000, 32'h8000_0000, 16'h8000);
        2: set_camera(32'h0, 32'h0, 16'($urandom));
        default: begin
          cx = $urandom;
          cy = $urandom;
          if ($urandom_range(1) == 0) begin
            cx = $urandom_range(2 * 1048576) - 1048576;
            cy = $urandom_range(2 * 1048576) - 1048576;
          end
          set_camera(cx, cy, 16'($urandom));
        end
      endcase
      if (p == 3) long_hold_due = 1'b1;
      if (p == RANDOM_PHASES - 1) quiet = 1'b1;
      for (j = 0; j < PHASE_ITEMS; j++) begin
        kind = $urandom_range(9);
        t.heading = 16'($urandom);
        t.x = $urandom;
        t.y = $urandom;
        case (kind)
          0: begin
            t.x = cam_x_q;
            t.y = cam_y_q;
          end
          1: t.x = cam_x_q;
          2: t.y = cam_y_q;
          3, 4: begin
            t.x = cam_x_q + $urandom_range(8192) - 4096;
            t.y = cam_y_q + $urandom_range(8192) - 4096;
          end
          5: begin
            t.x = ($urandom_range(1) == 0) ? 32'h7FFF_FFFF : 32'h8000_0000;
            t.y = ($urandom_range(1) == 0) ? 32'h7FFF_FFFF : 32'h8000_0000;
          end
          default: ;
        endcase
        push_target(t, 1'b0, '0);
      end
    end

    drain();
    repeat (LATENCY + 10) @(posedge clk);
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

>>> target_bearing_and_distance.f
+incdir+rtl/core
rtl/core/tbd_pkg.sv
rtl/core/tbd_front.sv
rtl/core/tbd_cell.sv
rtl/core/tbd_gain.sv
rtl/core/target_bearing_and_distance.sv
test/target_bearing_and_distance_tb.sv
